### sv/snco_pkg.sv
// ----------------------------------------------------------------------------
// snco_pkg
// Shared types, constants and the quarter-wave sine table generator for the
// phase-continuous sine oscillator.
// ----------------------------------------------------------------------------
package snco_pkg;

  localparam int PHASE_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int TABLE_BITS = 10;
  localparam int SAMPLE_W   = 16;
  localparam int QUARTER    = 1 << (TABLE_BITS - 2);
  localparam int IDX_W      = TABLE_BITS - 1;

  localparam logic [PHASE_W-1:0] STEP_RESET = 32'd21426141;
  localparam logic [63:0]        PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0]        AMPL       = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

  typedef enum logic [1:0] {
    CMD_TICK           = 2'd0,
    CMD_SET_INC        = 2'd1,
    CMD_SET_INC_SMOOTH = 2'd2,
    CMD_SET_OFFSET     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [PHASE_W-1:0] value;
    logic [PHASE_W-1:0] prod;
  } op_t;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b,
                                          int unsigned sh, logic [63:0] add);
    logic [127:0] full;
    full = ({64'd0, a} * {64'd0, b}) + {64'd0, add};
    full = full >> sh;
    return full[63:0];
  endfunction

  // Taylor series of sin in Q2.60, rounded half up to the output scale
  function automatic logic [SAMPLE_W-1:0] quarter_sine(int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    x    = mul_shr(PI_Q60, 64'(j), TABLE_BITS - 1, 64'd0);
    x2   = mul_shr(x, x, 60, 64'd0);
    term = x;
    sum  = x;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd6;   sum = sum - term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd20;  sum = sum + term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd42;  sum = sum - term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd72;  sum = sum + term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd110; sum = sum - term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd156; sum = sum + term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd210; sum = sum - term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd272; sum = sum + term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd342; sum = sum - term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd420; sum = sum + term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd506; sum = sum - term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd600; sum = sum + term;
    term = mul_shr(term, x2, 60, 64'd0) / 64'd702; sum = sum - term;
    q = mul_shr(sum, AMPL, 60, 64'd1 << 59);
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

### sv/snco_front.sv
// ----------------------------------------------------------------------------
// snco_front
// Accepts command items, tracks the tick count they see and forms the
// count-times-value product that the back end needs for increment changes.
// ----------------------------------------------------------------------------
module snco_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      cmd_i,
  input  logic [snco_pkg::PHASE_W-1:0]    value_i,
  output logic                            op_valid_o,
  input  logic                            op_ready_i,
  output snco_pkg::op_t                   op_o
);

  logic                           s_valid_q, s_valid_d;
  snco_pkg::cmd_e                 s_cmd_q;
  logic [snco_pkg::PHASE_W-1:0]   s_value_q;
  logic [snco_pkg::COUNT_W-1:0]   s_count_q;
  logic [snco_pkg::COUNT_W-1:0]   count_q, count_d;
  logic                           accept;
  logic                           is_tick;

  assign in_ready_o = !s_valid_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (snco_pkg::cmd_e'(cmd_i) == snco_pkg::CMD_TICK);

  always_comb begin
    count_d   = count_q;
    s_valid_d = s_valid_q;
    if (op_ready_i) begin
      s_valid_d = 1'b0;
    end
    if (accept) begin
      s_valid_d = 1'b1;
      if (is_tick) begin
        count_d = count_q + snco_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      count_q   <= '0;
    end else begin
      s_valid_q <= s_valid_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_cmd_q   <= snco_pkg::cmd_e'(cmd_i);
      s_value_q <= value_i;
      s_count_q <= count_q;
    end
  end

  assign op_valid_o = s_valid_q;
  assign op_o.cmd   = s_cmd_q;
  assign op_o.value = s_value_q;
  assign op_o.prod  = snco_pkg::PHASE_W'(s_count_q * s_value_q);

  a_count_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_tick |=> count_q == snco_pkg::COUNT_W'($past(count_q) + 1'b1))
    else $error("tick count did not advance");

endmodule

### sv/snco_queue.sv
// ----------------------------------------------------------------------------
// snco_queue
// Small FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module snco_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  snco_pkg::op_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output snco_pkg::op_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  snco_pkg::op_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue fill exceeds depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("queue fill did not follow push");

endmodule

### sv/snco_back.sv
// ----------------------------------------------------------------------------
// snco_back
// Executes operations against the phase state and runs ticks through the
// quarter-wave table lookup into the output register.
// ----------------------------------------------------------------------------
module snco_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  op_valid_i,
  output logic                                  op_ready_o,
  input  snco_pkg::op_t                         op_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [snco_pkg::SAMPLE_W-1:0]  sample_o,
  output logic [snco_pkg::PHASE_W-1:0]          increment_now_o,
  output logic [snco_pkg::PHASE_W-1:0]          offset_now_o
);

  localparam int PW = snco_pkg::PHASE_W;
  localparam int TB = snco_pkg::TABLE_BITS;
  localparam int IW = snco_pkg::IDX_W;
  localparam int SW = snco_pkg::SAMPLE_W;

  logic [SW-1:0] qtab [snco_pkg::QUARTER + 1];

  for (genvar g = 0; g <= snco_pkg::QUARTER; g++) begin : g_tab
    localparam logic [SW-1:0] ENTRY = snco_pkg::quarter_sine(g);
    assign qtab[g] = ENTRY;
  end

  logic [PW-1:0] step_q, step_d;
  logic [PW-1:0] offset_q, offset_d;
  logic [PW-1:0] phase_q, phase_d;

  logic          a_valid_q, a_valid_d;
  logic [IW-1:0] a_idx_q;
  logic          a_neg_q;
  logic [PW-1:0] a_step_q, a_off_q;

  logic          o_valid_q, o_valid_d;
  logic [SW-1:0] o_sample_q;
  logic [PW-1:0] o_step_q, o_off_q;

  logic          out_free, a_free, is_tick, pop, tick_pop;
  logic [1:0]    quad;
  logic [IW-1:0] j_ext, idx;
  logic [SW-1:0] tab_val;

  assign out_free   = !o_valid_q || out_ready_i;
  assign a_free     = !a_valid_q || out_free;
  assign is_tick    = (op_i.cmd == snco_pkg::CMD_TICK);
  assign op_ready_o = !is_tick || a_free;
  assign pop        = op_valid_i && op_ready_o;
  assign tick_pop   = pop && is_tick;

  assign quad  = phase_q[PW-1 -: 2];
  assign j_ext = {1'b0, phase_q[PW-TB +: TB-2]};
  assign idx   = quad[0] ? IW'(snco_pkg::QUARTER) - j_ext : j_ext;

  always_comb begin
    step_d   = step_q;
    offset_d = offset_q;
    phase_d  = phase_q;
    if (pop) begin
      case (op_i.cmd)
        snco_pkg::CMD_TICK: begin
          phase_d = phase_q + step_q;
        end
        snco_pkg::CMD_SET_INC: begin
          step_d  = op_i.value;
          phase_d = offset_q + op_i.prod;
        end
        snco_pkg::CMD_SET_INC_SMOOTH: begin
          step_d   = op_i.value;
          offset_d = phase_q - op_i.prod;
        end
        snco_pkg::CMD_SET_OFFSET: begin
          offset_d = op_i.value;
          phase_d  = phase_q - offset_q + op_i.value;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (out_free) begin
      a_valid_d = 1'b0;
    end
    if (tick_pop) begin
      a_valid_d = 1'b1;
    end
    o_valid_d = o_valid_q;
    if (out_ready_i) begin
      o_valid_d = 1'b0;
    end
    if (a_valid_q && out_free) begin
      o_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= snco_pkg::STEP_RESET;
      offset_q  <= '0;
      phase_q   <= '0;
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      offset_q  <= offset_d;
      phase_q   <= phase_d;
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  assign tab_val = qtab[a_idx_q];

  always_ff @(posedge clk_i) begin
    if (tick_pop) begin
      a_idx_q  <= idx;
      a_neg_q  <= quad[1];
      a_step_q <= step_q;
      a_off_q  <= offset_q;
    end
    if (a_valid_q && out_free) begin
      o_sample_q <= a_neg_q ? SW'(-tab_val) : tab_val;
      o_step_q   <= a_step_q;
      o_off_q    <= a_off_q;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign sample_o        = o_sample_q;
  assign increment_now_o = o_step_q;
  assign offset_now_o    = o_off_q;

  a_smooth_keeps_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && op_i.cmd == snco_pkg::CMD_SET_INC_SMOOTH |=> $stable(phase_q))
    else $error("smooth increment change moved the phase");

  a_lookup_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !out_free |=> a_valid_q && $stable(a_idx_q) && $stable(a_neg_q))
    else $error("stalled lookup stage changed");

endmodule

### sv/sine_oscillator_phase_continuous.sv
// ----------------------------------------------------------------------------
// sine_oscillator_phase_continuous
// Phase-continuous sine oscillator: commands set the phase increment or offset,
// ticks produce one sine sample with the current increment and offset.
// ----------------------------------------------------------------------------
// Path: front register, queue, lookup register, output register.
// Throughput: one item per cycle unless the output stalls; the phase adder
// and lookup are registered; the count-times-value multiply is front-end.
// Reset: increment 21426141, offset and sample count zero, queue empty.
module sine_oscillator_phase_continuous #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            cmd_i,
  input  logic [snco_pkg::PHASE_W-1:0]          value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [snco_pkg::SAMPLE_W-1:0]  sample_o,
  output logic [snco_pkg::PHASE_W-1:0]          increment_now_o,
  output logic [snco_pkg::PHASE_W-1:0]          offset_now_o
);

  logic          f_valid, f_ready;
  snco_pkg::op_t f_op;
  logic          b_valid, b_ready;
  snco_pkg::op_t b_op;

  snco_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  snco_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_op)
  );

  snco_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (b_valid),
    .op_ready_o      (b_ready),
    .op_i            (b_op),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_o        (sample_o),
    .increment_now_o (increment_now_o),
    .offset_now_o    (offset_now_o)
  );

endmodule

### sim/sine_oscillator_phase_continuous_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_oscillator_phase_continuous_tb
// Drives tick and increment/offset commands through the valid/ready input,
// tracks counter, increment and offset in a local sine oscillator model and
// compares every sample, increment and offset against it, under random gaps
// on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module sine_oscillator_phase_continuous_tb;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 1200;
  localparam int DRAIN_CYCLES    = 12;

  typedef struct {
    logic signed [snco_pkg::SAMPLE_W-1:0] sample;
    logic [snco_pkg::PHASE_W-1:0]         increment;
    logic [snco_pkg::PHASE_W-1:0]         offset;
  } tone_sample_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic [1:0]                           cmd_i;
  logic [snco_pkg::PHASE_W-1:0]         value_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [snco_pkg::SAMPLE_W-1:0] sample_o;
  logic [snco_pkg::PHASE_W-1:0]         increment_now_o;
  logic [snco_pkg::PHASE_W-1:0]         offset_now_o;

  logic signed [snco_pkg::SAMPLE_W-1:0] sine_quarter [0:snco_pkg::QUARTER];
  logic [snco_pkg::COUNT_W-1:0]         osc_count;
  logic [snco_pkg::PHASE_W-1:0]         osc_step;
  logic [snco_pkg::PHASE_W-1:0]         osc_offset;
  tone_sample_t                         pending_samples [$];

  int  fail_count;
  int  cycle_count;
  bit  tx_gaps;
  bit  rx_stalls;
  bit  hold_off_req;

  sine_oscillator_phase_continuous dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_o        (sample_o),
    .increment_now_o (increment_now_o),
    .offset_now_o    (offset_now_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] fx_mul_shift(logic [63:0] a, logic [63:0] b,
                                               int unsigned sh, logic [63:0] rnd);
    logic [127:0] wide;
    wide = ({64'd0, a} * {64'd0, b}) + {64'd0, rnd};
    wide = wide >> sh;
    return wide[63:0];
  endfunction

  function automatic logic signed [snco_pkg::SAMPLE_W-1:0] quarter_sine_q15(
      int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] scaled;
    int          n;
    x    = fx_mul_shift(snco_pkg::PI_Q60, 64'(idx), snco_pkg::TABLE_BITS - 1, 64'd0);
    x2   = fx_mul_shift(x, x, 60, 64'd0);
    term = x;
    acc  = x;
    for (n = 1; n <= 13; n++) begin
      term = fx_mul_shift(term, x2, 60, 64'd0) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    scaled = fx_mul_shift(acc, snco_pkg::AMPL, 60, 64'd1 << 59);
    return scaled[snco_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Update the oscillator state for one item; queue a sample for a tick
  task automatic osc_apply(snco_pkg::cmd_e cmd, logic [snco_pkg::PHASE_W-1:0] val);
    tone_sample_t                         res;
    logic [snco_pkg::PHASE_W-1:0]         phase;
    logic [snco_pkg::TABLE_BITS-1:0]      k;
    logic [1:0]                           quad;
    logic [snco_pkg::TABLE_BITS-3:0]      j;
    logic signed [snco_pkg::SAMPLE_W-1:0] v;
    case (cmd)
      snco_pkg::CMD_SET_INC: begin
        osc_step = val;
      end
      snco_pkg::CMD_SET_INC_SMOOTH: begin
        osc_offset = osc_offset + osc_count * (osc_step - val);
        osc_step   = val;
      end
      snco_pkg::CMD_SET_OFFSET: begin
        osc_offset = val;
      end
      default: begin
        phase = osc_offset + osc_count * osc_step;
        k     = phase[snco_pkg::PHASE_W-1 -: snco_pkg::TABLE_BITS];
        quad  = k[snco_pkg::TABLE_BITS-1 -: 2];
        j     = k[snco_pkg::TABLE_BITS-3:0];
        v     = quad[0] ? sine_quarter[snco_pkg::QUARTER - int'(j)] : sine_quarter[j];
        if (quad[1]) begin
          v = -v;
        end
        res.sample    = v;
        res.increment = osc_step;
        res.offset    = osc_offset;
        pending_samples.push_back(res);
        osc_count = osc_count + 1;
      end
    endcase
  endtask

  task automatic send_item(snco_pkg::cmd_e cmd, logic [snco_pkg::PHASE_W-1:0] val);
    int gap;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    osc_apply(cmd, val);
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      cmd_i      <= 2'($urandom);
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tone_sample_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected item sample %0d inc %h ofs %h", $time,
                 sample_o, increment_now_o, offset_now_o);
        fail_count++;
      end else begin
        exp_res = pending_samples.pop_front();
        if (sample_o !== exp_res.sample) begin
          $display("%0t: sample expected %0d got %0d", $time, exp_res.sample, sample_o);
          fail_count++;
        end
        if (increment_now_o !== exp_res.increment) begin
          $display("%0t: increment expected %h got %h", $time, exp_res.increment,
                   increment_now_o);
          fail_count++;
        end
        if (offset_now_o !== exp_res.offset) begin
          $display("%0t: offset expected %h got %h", $time, exp_res.offset, offset_now_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, pending_samples.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    repeat (3) send_item(snco_pkg::CMD_TICK, 32'd0);
  endtask

  task automatic test_phase_extremes();
    send_item(snco_pkg::CMD_SET_INC, 32'd0);
    send_item(snco_pkg::CMD_SET_OFFSET, 32'h4000_0000);
    send_item(snco_pkg::CMD_TICK, 32'hFFFF_FFFF);
    send_item(snco_pkg::CMD_SET_OFFSET, 32'h8000_0000);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_SET_OFFSET, 32'hC000_0000);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_SET_OFFSET, 32'hFFFF_FFFF);
    send_item(snco_pkg::CMD_TICK, 32'd0);
  endtask

  task automatic test_increment_changes();
    send_item(snco_pkg::CMD_SET_INC, 32'hFFFF_FFFF);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_SET_INC_SMOOTH, 32'h4000_0000);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_SET_INC_SMOOTH, 32'd0);
    send_item(snco_pkg::CMD_TICK, 32'd0);
    send_item(snco_pkg::CMD_SET_OFFSET, 32'd0);
    send_item(snco_pkg::CMD_SET_INC_SMOOTH, 32'h0040_0000);
    send_item(snco_pkg::CMD_TICK, 32'd0);
  endtask

  task automatic test_output_hold_off();
    tx_gaps      = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_item(snco_pkg::CMD_TICK, $urandom);
    tx_gaps      = 1'b1;
  endtask

  task automatic test_random_stream();
    int             i;
    int unsigned    r;
    snco_pkg::cmd_e cmd;
    logic [31:0]    val;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        tx_gaps = (i / 150) % 3 != 1;
      end
      if (i % 200 == 0) begin
        rx_stalls = (i / 200) % 3 != 2;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        cmd = snco_pkg::CMD_TICK;
      end else if (r < 73) begin
        cmd = snco_pkg::CMD_SET_INC;
      end else if (r < 87) begin
        cmd = snco_pkg::CMD_SET_INC_SMOOTH;
      end else begin
        cmd = snco_pkg::CMD_SET_OFFSET;
      end
      case ($urandom_range(0, 7))
        0:       val = 32'd0;
        1:       val = 32'hFFFF_FFFF;
        2, 3:    val = $urandom_range(0, 32'h0100_0000);
        default: val = $urandom;
      endcase
      send_item(cmd, val);
    end
  endtask

  initial begin
    int q;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = snco_pkg::CMD_TICK;
    value_i      = '0;
    out_ready_i  = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;
    tx_gaps      = 1'b1;
    rx_stalls    = 1'b1;
    hold_off_req = 1'b0;
    osc_count    = '0;
    osc_step     = snco_pkg::STEP_RESET;
    osc_offset   = '0;
    for (q = 0; q <= snco_pkg::QUARTER; q++) begin
      sine_quarter[q] = quarter_sine_q15(q);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_phase_extremes();
    test_increment_changes();
    test_output_hold_off();
    test_random_stream();

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/snco_pkg.sv
sv/snco_front.sv
sv/snco_queue.sv
sv/snco_back.sv
sv/sine_oscillator_phase_continuous.sv
sim/sine_oscillator_phase_continuous_tb.sv
